>>> rtl/fke_pkg.sv
// Shared types and constants for the FASTQ k-mer extractor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fke_pkg;

    localparam int unsigned KmerW  = 64;
    localparam int unsigned SymW   = 8;
    localparam int unsigned LenW   = 6;
    localparam int unsigned KindW  = 2;
    localparam int unsigned CfgIdxW = 2;

    typedef logic [KmerW-1:0] t_kmer;
    typedef logic [SymW-1:0]  t_sym;
    typedef logic [LenW-1:0]  t_len;
    typedef logic [KindW-1:0] t_kind;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_KMER_LENGTH     = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_START_LINE_KIND = 2'd1;

    // Record line kinds.
    localparam t_kind LINE_HEADER   = 2'd0;
    localparam t_kind LINE_SEQUENCE = 2'd1;
    localparam t_kind LINE_PLUS     = 2'd2;
    localparam t_kind LINE_QUALITY  = 2'd3;

    // Characters of interest.
    localparam t_sym CHAR_A       = 8'h41;
    localparam t_sym CHAR_C       = 8'h43;
    localparam t_sym CHAR_G       = 8'h47;
    localparam t_sym CHAR_T       = 8'h54;
    localparam t_sym CHAR_NEWLINE = 8'h0A;

    // Base codes.
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    // One result as handed from the core to the output buffer.
    typedef struct packed {
        logic  valid;
        t_kmer code;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/fke_core.sv
// Line tracking, base decoding and rolling k-mer state of the extractor.
// Depends on fke_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fke_core
    import fke_pkg::*;
#(
    parameter int MAX_KMER_LENGTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CfgIdxW-1:0] i_cfg_index,
    input  wire logic [LenW-1:0]    i_cfg_data,
    input  wire logic               i_accept,
    input  wire t_sym               i_symbol,
    output t_result                 o_result
);

    localparam t_len MaxK = LenW'(MAX_KMER_LENGTH);

    t_len  r_kmer_length;
    t_kind r_start_kind;
    t_kind r_line;
    logic  r_started;
    t_kmer r_kmer;
    t_len  r_filled;

    t_len  k_eff;
    t_kmer mask;
    t_kind cur_line;
    logic  is_base;
    logic  [1:0] base;
    t_kind n_line;
    t_kmer n_kmer;
    t_len  n_filled;
    logic  emit;

    always_comb begin
        if (r_kmer_length == '0) begin
            k_eff = LenW'(1);
        end else if (r_kmer_length > MaxK) begin
            k_eff = MaxK;
        end else begin
            k_eff = r_kmer_length;
        end
    end

    // Keep the low 2k bits of the k-mer.
    always_comb begin
        for (int j = 0; j < KmerW; j++) begin
            mask[j] = (7'(j) < {k_eff, 1'b0});
        end
    end

    always_comb begin
        is_base = 1'b1;
        base    = BASE_A;
        case (i_symbol)
            CHAR_A:  base = BASE_A;
            CHAR_C:  base = BASE_C;
            CHAR_G:  base = BASE_G;
            CHAR_T:  base = BASE_T;
            default: is_base = 1'b0;
        endcase
    end

    always_comb begin
        cur_line = r_started ? r_line : r_start_kind;
        n_line   = cur_line;
        n_kmer   = r_kmer;
        n_filled = r_filled;
        emit     = 1'b0;
        if (i_symbol == CHAR_NEWLINE) begin
            n_line   = cur_line + KindW'(1);
            n_kmer   = '0;
            n_filled = '0;
        end else if (cur_line == LINE_SEQUENCE) begin
            if (!is_base) begin
                n_kmer   = '0;
                n_filled = '0;
            end else begin
                n_kmer = {r_kmer[KmerW-3:0], base} & mask;
                if (r_filled < k_eff) begin
                    n_filled = r_filled + LenW'(1);
                end else begin
                    // The length may have been lowered since the last item.
                    n_filled = k_eff;
                end
                emit = (n_filled == k_eff);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length <= LenW'(31);
            r_start_kind  <= LINE_HEADER;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_KMER_LENGTH) begin
                r_kmer_length <= i_cfg_data;
            end else if (i_cfg_index == CFG_START_LINE_KIND) begin
                r_start_kind <= i_cfg_data[KindW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line    <= LINE_HEADER;
            r_started <= 1'b0;
            r_kmer    <= '0;
            r_filled  <= '0;
        end else if (i_accept) begin
            r_line    <= n_line;
            r_started <= 1'b1;
            r_kmer    <= n_kmer;
            r_filled  <= n_filled;
        end
    end

    assign o_result.valid = i_accept && emit;
    assign o_result.code  = n_kmer;

endmodule

`default_nettype wire

>>> rtl/fke_out_buf.sv
// Output register with one skid entry, so a new byte is taken while a
// finished k-mer waits. Depends on fke_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fke_out_buf
    import fke_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_result i_result,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_kmer        o_kmer_code
);

    logic  r_out_valid;
    t_kmer r_out_code;
    logic  r_skid_valid;
    t_kmer r_skid_code;
    logic  take;

    assign take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_result.valid) begin
            // A push only happens while the skid entry is empty.
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid) begin
            if (!r_out_valid || take) begin
                r_out_code <= i_result.code;
            end else begin
                r_skid_code <= i_result.code;
            end
        end else if (take && r_skid_valid) begin
            r_out_code <= r_skid_code;
        end
    end

    assign o_full      = r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_kmer_code = r_out_code;

endmodule

`default_nettype wire

>>> rtl/fastq_kmer_extractor_top.sv
// Top level of the FASTQ k-mer extractor: core state plus output buffer.
// Depends on fke_pkg, fke_core and fke_out_buf.
//
//  Channel   Signals                                   Direction
//  input     i_valid, o_stall, i_symbol[7:0]           byte in
//  output    o_valid, i_stall, o_kmer_code[63:0]       k-mer out
//  config    i_cfg_we, i_cfg_index[1:0], i_cfg_data    register write
//
// One byte is taken per cycle while o_stall is low; its k-mer, if any,
// goes to the output register. The single state update of line kind, k-mer
// and fill count sets this rate. Synchronous reset sets the length to 31,
// the start line kind to header and clears all but the buffer codes; that
// kind is sampled at the first byte after reset. A stalled output holds one
// more k-mer in a skid entry and raises o_stall until the first is taken.
`timescale 1ns / 1ps
`default_nettype none

module fastq_kmer_extractor_top
    import fke_pkg::*;
#(
    parameter int MAX_KMER_LENGTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CfgIdxW-1:0] i_cfg_index,
    input  wire logic [LenW-1:0]    i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [SymW-1:0]    i_symbol,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [KmerW-1:0]        o_kmer_code
);

    t_result result;
    logic    full;
    logic    accept;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    fke_core #(
        .MAX_KMER_LENGTH(MAX_KMER_LENGTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_symbol    (i_symbol),
        .o_result    (result)
    );

    fke_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (result),
        .o_full      (full),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kmer_code (o_kmer_code)
    );

endmodule

`default_nettype wire
